// ===== rtl/core/sobel_pkg.sv =====
package sobel_pkg;

	// Line store geometry
	localparam int MAX_WIDTH = 1024;
	localparam int ADDR_W    = $clog2(MAX_WIDTH);

	// Field and register widths
	localparam int PIX_W    = 8;
	localparam int COORD_W  = 10;
	localparam int THRESH_W = 10;
	localparam int SIZE_W   = 11;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 11;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_EDGE_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT   = 2'd2;

	// Register reset values
	localparam logic [THRESH_W-1:0] THRESH_RESET = 10'd128;
	localparam logic [SIZE_W-1:0]   WIDTH_RESET  = 11'd640;
	localparam logic [SIZE_W-1:0]   HEIGHT_RESET = 11'd480;

	// Frame size limits
	localparam logic [SIZE_W-1:0] SIZE_MIN = 11'd3;
	localparam logic [SIZE_W-1:0] SIZE_MAX = 11'd1024;
	localparam logic [SIZE_W-1:0] WIDTH_MAX =
		(MAX_WIDTH < 1024) ? SIZE_W'(MAX_WIDTH) : SIZE_MAX;

	// Bookkeeping that follows a pixel down the pipe
	typedef struct packed {
		logic               produce;
		logic [ADDR_W-1:0]  addr;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               last;
	} meta_t;

	function automatic logic [SIZE_W-1:0] clamp_size(
		input logic [SIZE_W-1:0] v,
		input logic [SIZE_W-1:0] hi
	);
		logic [SIZE_W-1:0] r;
		if (v < SIZE_MIN)
			r = SIZE_MIN;
		else if (v > hi)
			r = hi;
		else
			r = v;
		return r;
	endfunction

endpackage

// ===== rtl/core/sobel_edge_threshold_core.sv =====
// Channel | Direction | Accepted when              | Contents
// s_axis  | in        | s_axis_tvalid & tready     | tdata: pixel
// m_axis  | out       | m_axis_tvalid & tready     | tdata: col,row,flags; tlast: frame end
// cfg     | in        | cfg_we                     | cfg_index selects, cfg_data written
//
// One pixel a cycle, sustained while results are being taken.
// The rate is set by the single line RAM: one read at accept, one write as
// that pixel moves on from the first stage, always to different columns.
// Reset clears counters, pipe valids, window and registers; the RAM keeps
// whatever it holds. The whole pipe halts while a result waits untaken.
module sobel_edge_threshold_core (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] pixel

	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [23:0] m_axis_tdata,   // [9:0] center_col, [19:10] center_row,
	                                    // [20] edge_vertical_grad,
	                                    // [21] edge_horizontal_grad, [22] edge_any,
	                                    // [23] zero
	output logic        m_axis_tlast,   // frame_last

	input  logic                         cfg_we,
	input  logic [sobel_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sobel_pkg::CFG_DATA_W-1:0] cfg_data
);

	import sobel_pkg::*;

	// ---------------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------------
	logic [THRESH_W-1:0] thresh_q;
	logic [SIZE_W-1:0]   width_q;
	logic [SIZE_W-1:0]   height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_EDGE_THRESHOLD: thresh_q <= cfg_data[THRESH_W-1:0];
				REG_IMAGE_WIDTH:    width_q  <= cfg_data[SIZE_W-1:0];
				REG_IMAGE_HEIGHT:   height_q <= cfg_data[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	logic [SIZE_W-1:0] w_used;
	logic [SIZE_W-1:0] h_used;

	assign w_used = clamp_size(width_q, WIDTH_MAX);
	assign h_used = clamp_size(height_q, SIZE_MAX);

	// ---------------------------------------------------------------------
	// Pipe control: every stage advances together whenever the output
	// register is free or being drained.
	// ---------------------------------------------------------------------
	logic adv;
	logic accept;

	assign adv           = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = adv;
	assign accept        = s_axis_tvalid && adv;

	// ---------------------------------------------------------------------
	// Raster counters
	// ---------------------------------------------------------------------
	logic [COORD_W-1:0] col_q;
	logic [COORD_W-1:0] row_q;
	logic [SIZE_W-1:0]  c_cur;
	logic [SIZE_W-1:0]  r_pre;
	logic [SIZE_W-1:0]  r_cur;
	logic [SIZE_W-1:0]  c_inc;
	logic [SIZE_W-1:0]  r_inc;
	meta_t              meta_p0;

	always_comb begin
		// wrap left over from a size change: bring the position into range
		if ({1'b0, col_q} >= w_used) begin
			c_cur = '0;
			r_pre = {1'b0, row_q} + SIZE_W'(1);
		end else begin
			c_cur = {1'b0, col_q};
			r_pre = {1'b0, row_q};
		end
		r_cur = (r_pre >= h_used) ? '0 : r_pre;
		c_inc = c_cur + SIZE_W'(1);
		r_inc = r_cur + SIZE_W'(1);

		meta_p0.produce = (c_cur >= SIZE_W'(2)) && (r_cur >= SIZE_W'(2));
		meta_p0.addr    = c_cur[ADDR_W-1:0];
		meta_p0.col     = COORD_W'(c_cur - SIZE_W'(1));
		meta_p0.row     = COORD_W'(r_cur - SIZE_W'(1));
		meta_p0.last    = (c_inc == w_used) && (r_inc == h_used);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (c_inc >= w_used) begin
				col_q <= '0;
				row_q <= (r_inc >= h_used) ? '0 : r_inc[COORD_W-1:0];
			end else begin
				col_q <= c_inc[COORD_W-1:0];
				row_q <= r_cur[COORD_W-1:0];
			end
		end
	end

	// ---------------------------------------------------------------------
	// Line RAM: upper line in the high byte, middle line in the low byte.
	// Read at accept, write back the shifted column one stage later.
	// ---------------------------------------------------------------------
	logic                 valid_s1;
	meta_t                meta_s1;
	logic [PIX_W-1:0]     px_s1;
	logic [2*PIX_W-1:0]   ram_rdata;
	logic                 ram_we;
	logic [PIX_W-1:0]     up_rd;
	logic [PIX_W-1:0]     mid_rd;

	assign ram_we = valid_s1 && adv;
	assign up_rd  = ram_rdata[2*PIX_W-1:PIX_W];
	assign mid_rd = ram_rdata[PIX_W-1:0];

	sobel_line_ram #(
		.DEPTH (MAX_WIDTH),
		.WIDTH (2 * PIX_W)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (meta_s1.addr),
		.wdata ({mid_rd, px_s1}),
		.re    (accept),
		.raddr (meta_p0.addr),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (adv)
			valid_s1 <= accept;
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			px_s1   <= s_axis_tdata;
			meta_s1 <= meta_p0;
		end
	end

	// ---------------------------------------------------------------------
	// 3x3 window: shift left, load the new right column
	// ---------------------------------------------------------------------
	logic [PIX_W-1:0] win_q [9];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++)
				win_q[i] <= '0;
		end else if (ram_we) begin
			win_q[0] <= win_q[1];
			win_q[1] <= win_q[2];
			win_q[2] <= up_rd;
			win_q[3] <= win_q[4];
			win_q[4] <= win_q[5];
			win_q[5] <= mid_rd;
			win_q[6] <= win_q[7];
			win_q[7] <= win_q[8];
			win_q[8] <= px_s1;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: kernel responses from the window; only interior pixels go on
	// ---------------------------------------------------------------------
	logic  valid_s2;
	meta_t meta_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s2 <= 1'b0;
		else if (adv)
			valid_s2 <= valid_s1 && meta_s1.produce;
	end

	always_ff @(posedge clk) begin
		if (adv)
			meta_s2 <= meta_s1;
	end

	logic [COORD_W-1:0] sum_top;
	logic [COORD_W-1:0] sum_bot;
	logic [COORD_W-1:0] sum_left;
	logic [COORD_W-1:0] sum_right;
	logic [COORD_W:0]   diff_v;
	logic [COORD_W:0]   diff_h;
	logic [COORD_W:0]   neg_v;
	logic [COORD_W:0]   neg_h;

	always_comb begin
		sum_top   = COORD_W'(win_q[0]) + {1'b0, win_q[1], 1'b0} + COORD_W'(win_q[2]);
		sum_bot   = COORD_W'(win_q[6]) + {1'b0, win_q[7], 1'b0} + COORD_W'(win_q[8]);
		sum_left  = COORD_W'(win_q[0]) + {1'b0, win_q[3], 1'b0} + COORD_W'(win_q[6]);
		sum_right = COORD_W'(win_q[2]) + {1'b0, win_q[5], 1'b0} + COORD_W'(win_q[8]);
		diff_v    = {1'b0, sum_bot} - {1'b0, sum_top};
		diff_h    = {1'b0, sum_right} - {1'b0, sum_left};
		neg_v     = -diff_v;
		neg_h     = -diff_h;
	end

	// ---------------------------------------------------------------------
	// Stage 3: magnitudes (at most four times full scale, fits ten bits)
	// ---------------------------------------------------------------------
	logic                valid_s3;
	meta_t               meta_s3;
	logic [THRESH_W-1:0] mag_v_s3;
	logic [THRESH_W-1:0] mag_h_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s3 <= 1'b0;
		else if (adv)
			valid_s3 <= valid_s2;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			meta_s3  <= meta_s2;
			mag_v_s3 <= diff_v[COORD_W] ? neg_v[THRESH_W-1:0] : diff_v[THRESH_W-1:0];
			mag_h_s3 <= diff_h[COORD_W] ? neg_h[THRESH_W-1:0] : diff_h[THRESH_W-1:0];
		end
	end

	// ---------------------------------------------------------------------
	// Output register: threshold compare, hold until the transaction ends
	// ---------------------------------------------------------------------
	logic               out_valid_q;
	logic [COORD_W-1:0] out_col_q;
	logic [COORD_W-1:0] out_row_q;
	logic               out_ev_q;
	logic               out_eh_q;
	logic               out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (adv)
			out_valid_q <= valid_s3;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_col_q  <= meta_s3.col;
			out_row_q  <= meta_s3.row;
			out_ev_q   <= mag_v_s3 > thresh_q;
			out_eh_q   <= mag_h_s3 > thresh_q;
			out_last_q <= meta_s3.last;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {1'b0, out_ev_q | out_eh_q, out_eh_q, out_ev_q,
	                        out_row_q, out_col_q};
	assign m_axis_tlast  = out_last_q;

`ifndef SYNTHESIS
	// a write-back and a fresh read must never meet on one column
	a_ram_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && accept) |-> (meta_s1.addr != meta_p0.addr))
		else $error("line RAM read and write hit the same column");

	// results describe interior pixels only
	a_interior_only: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (out_col_q != '0) && (out_row_q != '0))
		else $error("result for a border pixel");

	// a stalled result stays until taken
	a_hold_stalled: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("stalled result dropped");
`endif

endmodule

// ===== rtl/core/sobel_line_ram.sv =====
module sobel_line_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 16,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// registered read, held while no read is issued
	always_ff @(posedge clk) begin
		if (re)
			rdata <= mem[raddr];
	end

endmodule

// ===== tb/sobel_edge_threshold_core_tb.sv =====
module sobel_edge_threshold_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import sobel_pkg::*;

	// Index with no register behind it: a write there must change nothing
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	// Generous bound on the whole run, and the pause that covers the pipe
	// latency once the last expected result has been taken
	localparam int CYCLE_LIMIT  = 40_000;
	localparam int DRAIN_CYCLES = 12;

	typedef enum int {STYLE_NOISE, STYLE_SMOOTH, STYLE_STEP} pix_style_t;

	// One edge result as it leaves on the master side
	typedef struct packed {
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               vert_edge;
		logic               horz_edge;
		logic               any_edge;
		logic               frame_end;
	} edge_result_t;

	logic                  clk           = 1'b0;
	logic                  arst_n        = 1'b0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [7:0]            s_axis_tdata  = '0;   // [7:0] pixel
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [23:0]           m_axis_tdata;         // [9:0] center_col, [19:10] center_row,
	                                             // [20] vertical, [21] horizontal, [22] any
	logic                  m_axis_tlast;         // frame_last
	logic                  cfg_we        = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_DATA_W-1:0] cfg_data      = '0;

	// Register copies, as written
	logic [THRESH_W-1:0] thresh_copy = THRESH_RESET;
	logic [SIZE_W-1:0]   width_copy  = WIDTH_RESET;
	logic [SIZE_W-1:0]   height_copy = HEIGHT_RESET;

	// Own copy of the line stores, the 3x3 neighbourhood and the raster position
	logic [7:0] upper_line  [MAX_WIDTH] = '{default: '0};
	logic [7:0] middle_line [MAX_WIDTH] = '{default: '0};
	logic [7:0] nbhd        [9]         = '{default: '0};
	int         col_pos = 0;
	int         row_pos = 0;

	edge_result_t expected_edges [$];

	int mismatches     = 0;
	int cycles         = 0;
	int src_idle_pct   = 0;
	int sink_stall_pct = 0;
	int level          = 128;

	sobel_edge_threshold_core dut (.*);

	always #2 clk = ~clk;

	// Frame size actually in force for a register value
	function automatic int size_in_use(logic [SIZE_W-1:0] size_reg);
		if (size_reg < 3)
			return 3;
		if (size_reg > 1024)
			return 1024;
		return int'(size_reg);
	endfunction

	// Advance the raster by one pixel and queue the edge result it completes, if any
	function automatic void predict_edges(logic [7:0] px);
		int           w, h, vert, horz;
		int           g [9];
		logic [7:0]   up, mid;
		edge_result_t res;
		w = size_in_use(width_copy);
		h = size_in_use(height_copy);
		// a counter left beyond a shrunken size wraps here
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (row_pos >= h)
			row_pos = 0;
		up  = upper_line[col_pos];
		mid = middle_line[col_pos];
		nbhd[0] = nbhd[1]; nbhd[1] = nbhd[2]; nbhd[2] = up;
		nbhd[3] = nbhd[4]; nbhd[4] = nbhd[5]; nbhd[5] = mid;
		nbhd[6] = nbhd[7]; nbhd[7] = nbhd[8]; nbhd[8] = px;
		upper_line[col_pos]  = mid;
		middle_line[col_pos] = px;
		if (col_pos >= 2 && row_pos >= 2) begin
			foreach (g[k])
				g[k] = int'(nbhd[k]);
			vert = (g[6] + 2 * g[7] + g[8]) - (g[0] + 2 * g[1] + g[2]);
			horz = (g[2] + 2 * g[5] + g[8]) - (g[0] + 2 * g[3] + g[6]);
			if (vert < 0)
				vert = -vert;
			if (horz < 0)
				horz = -horz;
			res.col       = COORD_W'(col_pos - 1);
			res.row       = COORD_W'(row_pos - 1);
			res.vert_edge = vert > int'(thresh_copy);
			res.horz_edge = horz > int'(thresh_copy);
			res.any_edge  = res.vert_edge | res.horz_edge;
			res.frame_end = (col_pos == w - 1) && (row_pos == h - 1);
			expected_edges.push_back(res);
		end
		col_pos++;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
			if (row_pos >= h)
				row_pos = 0;
		end
	endfunction

	function automatic void check_field(string what, int want, int got);
		if (want != got) begin
			mismatches++;
			if (mismatches <= 40)
				$display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
		end
	endfunction

	// Idle cycles ahead of a transaction: each cycle idles with the given chance
	function automatic int draw_gap(int pct);
		int n;
		n = 0;
		while ($urandom_range(99) < pct)
			n++;
		return n;
	endfunction

	function automatic logic [7:0] draw_pixel(pix_style_t style);
		int v;
		case (style)
			STYLE_NOISE: v = $urandom_range(255);
			STYLE_STEP:  v = $urandom_range(1) ? $urandom_range(255, 192) : $urandom_range(63);
			default: begin
				// drift a level slowly and add a little noise, so responses sit near
				// the usual thresholds
				level += int'($urandom_range(16)) - 8;
				if (level < 0)
					level = 0;
				else if (level > 255)
					level = 255;
				v = level + int'($urandom_range(40)) - 20;
				if (v < 0)
					v = 0;
				else if (v > 255)
					v = 255;
			end
		endcase
		return v[7:0];
	endfunction

	function automatic logic [CFG_DATA_W-1:0] draw_reg_value(logic [CFG_IDX_W-1:0] idx);
		logic [CFG_DATA_W-1:0] v;
		v = CFG_DATA_W'($urandom);
		if (idx == REG_EDGE_THRESHOLD) begin
			// the bit above the threshold field stays random: the register drops it
			case ($urandom_range(5))
				0: v[THRESH_W-1:0] = '0;
				1: v[THRESH_W-1:0] = '1;
				2: ;
				default: v[THRESH_W-1:0] = THRESH_W'($urandom_range(20, 300));
			endcase
		end else if (idx == REG_IMAGE_WIDTH) begin
			// keep lines within the columns already filled; below three tests the clamp
			v = CFG_DATA_W'($urandom_range(24));
		end else if ($urandom_range(9) != 0) begin
			// small frames keep results coming; the odd raw value tests the clamp
			v = CFG_DATA_W'($urandom_range(12));
		end
		return v;
	endfunction

	// Write one register; hold the enable for a single edge, then drop it
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_EDGE_THRESHOLD: thresh_copy = value[THRESH_W-1:0];
			REG_IMAGE_WIDTH:    width_copy  = value;
			REG_IMAGE_HEIGHT:   height_copy = value;
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic retune(int slot);
		case (slot)
			0:       write_reg(REG_EDGE_THRESHOLD, draw_reg_value(REG_EDGE_THRESHOLD));
			1:       write_reg(REG_IMAGE_WIDTH, draw_reg_value(REG_IMAGE_WIDTH));
			default: write_reg(REG_IMAGE_HEIGHT, draw_reg_value(REG_IMAGE_HEIGHT));
		endcase
	endtask

	// Offer one pixel, after a random gap, and wait for its transaction
	task automatic send_pixel(logic [7:0] px);
		int gap;
		gap = draw_gap(src_idle_pct);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= px;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_edges(px);
	endtask

	// Hold the sender until every expected result has been taken, then let the
	// pipe empty of pixels that produce nothing
	task automatic settle();
		s_axis_tvalid <= 1'b0;
		while (expected_edges.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Reset values in force: 640 wide, threshold 128. Part of the first line
	// gives nothing; a narrower line then gives results at the reset threshold.
	task automatic test_reset_values();
		src_idle_pct   = 0;
		sink_stall_pct = 0;
		repeat (40)
			send_pixel(draw_pixel(STYLE_SMOOTH));
		settle();
		write_reg(REG_IMAGE_WIDTH, 11'd8);
		repeat (24)
			send_pixel(draw_pixel(STYLE_SMOOTH));
		settle();
	endtask

	// Hand-built frames: a response equal to the threshold, a clear horizontal
	// edge, pixel extremes, the smallest frame and the highest threshold
	task automatic test_kernel_cases();
		logic [7:0] strip [15];
		logic [7:0] tiny  [9];
		strip = '{8'd0,  8'd0,  8'd0,  8'd0, 8'd255,
		          8'd0,  8'd0,  8'd0,  8'd0, 8'd255,
		          8'd32, 8'd32, 8'd32, 8'd0, 8'd255};
		tiny  = '{8'd0,   8'd0,   8'd0,
		          8'd0,   8'd0,   8'd0,
		          8'd255, 8'd255, 8'd255};
		src_idle_pct   = 30;
		sink_stall_pct = 30;
		write_reg(REG_UNUSED, '1);
		// the frame left from before stops part-way: the counters wrap to a fresh frame
		write_reg(REG_IMAGE_WIDTH, 11'd5);
		write_reg(REG_IMAGE_HEIGHT, 11'd3);
		write_reg(REG_EDGE_THRESHOLD, 11'd128);
		foreach (strip[i])
			send_pixel(strip[i]);
		settle();
		// the largest response, 1020, still stays below the top threshold
		write_reg(REG_EDGE_THRESHOLD, 11'd1023);
		write_reg(REG_IMAGE_WIDTH, 11'd3);
		foreach (tiny[i])
			send_pixel(tiny[i]);
		settle();
	endtask

	// Sizes below and above the legal range: a whole frame where it is small,
	// the opening pixels only where a size is clamped to the top
	task automatic test_size_limits();
		logic [SIZE_W-1:0] widths  [4];
		logic [SIZE_W-1:0] heights [4];
		int                n;
		widths  = '{11'd2, 11'd2047, 11'd0,    11'd1};
		heights = '{11'd2, 11'd1,    11'd2047, 11'd0};
		for (int i = 0; i < 4; i++) begin
			src_idle_pct   = (i % 2 == 1) ? 48 : 0;
			sink_stall_pct = (i >= 2) ? 48 : 0;
			write_reg(REG_IMAGE_WIDTH, widths[i]);
			write_reg(REG_IMAGE_HEIGHT, heights[i]);
			write_reg(REG_EDGE_THRESHOLD, CFG_DATA_W'($urandom_range(400)));
			n = size_in_use(widths[i]) * size_in_use(heights[i]);
			if (n > 30)
				n = 30;
			repeat (n)
				send_pixel(draw_pixel(STYLE_NOISE));
			settle();
		end
	endtask

	// Registers changed part-way through a frame: counters carry on and wrap
	// where they now lie beyond the size
	task automatic test_mid_frame_changes();
		src_idle_pct   = 48;
		sink_stall_pct = 0;
		write_reg(REG_IMAGE_WIDTH, 11'd10);
		write_reg(REG_IMAGE_HEIGHT, 11'd7);
		write_reg(REG_EDGE_THRESHOLD, 11'd100);
		for (int i = 0; i < 6; i++) begin
			repeat ($urandom_range(10, 30))
				send_pixel(draw_pixel(STYLE_SMOOTH));
			settle();
			retune(i % 3);
		end
	endtask

	// Random frames under each idling pattern, with occasional pauses and
	// register changes between bursts
	task automatic test_random_traffic();
		int         src_pct  [4];
		int         sink_pct [4];
		int         sent, burst;
		pix_style_t style;
		src_pct  = '{0, 48, 0, 30};
		sink_pct = '{0, 0, 48, 30};
		for (int p = 0; p < 4; p++) begin
			src_idle_pct   = src_pct[p];
			sink_stall_pct = sink_pct[p];
			for (int s = 0; s < 3; s++)
				retune(s);
			sent = 0;
			while (sent < 60) begin
				style = pix_style_t'($urandom_range(2));
				burst = $urandom_range(10, 30);
				repeat (burst)
					send_pixel(draw_pixel(style));
				sent += burst;
				if ($urandom_range(2) == 0) begin
					settle();
					retune($urandom_range(2));
				end
			end
			settle();
		end
	endtask

	// Take results under random back-pressure and compare each with the oldest
	// expectation
	always @(posedge clk) begin
		edge_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_edges.size() == 0) begin
				mismatches++;
				if (mismatches <= 40)
					$display("%0t: unexpected result: expected nothing, got col %0d row %0d",
						$time, m_axis_tdata[9:0], m_axis_tdata[19:10]);
			end else begin
				want = expected_edges.pop_front();
				check_field("center_col", want.col, m_axis_tdata[9:0]);
				check_field("center_row", want.row, m_axis_tdata[19:10]);
				check_field("edge_vertical_grad", want.vert_edge, m_axis_tdata[20]);
				check_field("edge_horizontal_grad", want.horz_edge, m_axis_tdata[21]);
				check_field("edge_any", want.any_edge, m_axis_tdata[22]);
				check_field("frame_last", want.frame_end, m_axis_tlast);
			end
		end
		m_axis_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("%0t: no progress within %0d cycles", $time, CYCLE_LIMIT);
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_kernel_cases();
		test_size_limits();
		test_mid_frame_changes();
		test_random_traffic();
		settle();
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/core/sobel_pkg.sv
rtl/core/sobel_line_ram.sv
rtl/core/sobel_edge_threshold_core.sv
tb/sobel_edge_threshold_core_tb.sv
